>>> rtl/core/phs_pkg.sv
package phs_pkg;

  localparam int unsigned RowsDefault = 32;
  localparam int unsigned ColsDefault = 16;

  localparam int TempW    = 24;
  localparam int LevelW   = 4;
  localparam int StepW    = 16;
  localparam int ChangeW  = 39;
  localparam int RowW     = 5;
  localparam int ColW     = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 39;

  // n / 10 == (n * RECIP10) >> RECIP_SHIFT for every n below 2^32.
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [LevelW-1:0] LEVEL_MAX = 4'd9;

  localparam logic [CfgIdxW-1:0] CFG_RANGE_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD  = 2'd2;

  localparam logic signed [TempW-1:0] RANGE_HIGH_RST = 24'sd25600;
  localparam logic signed [TempW-1:0] RANGE_LOW_RST  = 24'sd0;
  localparam logic [ChangeW-1:0]      THRESHOLD_RST  = 39'd256;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                     command;
    logic [RowW-1:0]          row;
    logic [ColW-1:0]          col;
    logic signed [TempW-1:0]  temperature;
  } in_t;

  typedef struct packed {
    logic signed [TempW-1:0]  cell_temp;
    logic [LevelW-1:0]        level;
    logic [StepW-1:0]         step_count;
    logic [ChangeW-1:0]       total_change;
    logic                     converged;
  } out_t;

endpackage

>>> rtl/core/phs_ram.sv
module phs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/phs_stencil.sv
module phs_stencil #(
  parameter int unsigned Rows = phs_pkg::RowsDefault,
  parameter int unsigned Cols = phs_pkg::ColsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                in_valid_i,
  input  logic signed [phs_pkg::TempW-1:0]    in_data_i,
  output logic                                wr_valid_o,
  output logic [$clog2(Rows*Cols)-1:0]        wr_addr_o,
  output logic signed [phs_pkg::TempW-1:0]    wr_data_o,
  output logic [phs_pkg::ChangeW-1:0]         total_o,
  output logic                                busy_o
);
  import phs_pkg::*;

  localparam int unsigned Cells   = Rows * Cols;
  localparam int          AddrW   = $clog2(Cells);
  localparam int          RowCntW = $clog2(Rows);
  localparam int          ColCntW = $clog2(Cols);
  localparam int unsigned LineLen = 2 * Cols + 3;
  localparam int          PartW   = TempW + 3;
  localparam int          SumW    = TempW + 4;
  localparam int          MagW    = SumW - 1;
  localparam int          ProdW   = MagW + 32;
  localparam int          DiffW   = TempW + 1;

  // Two rows plus three cells of the incoming raster; entry k holds the cell k places back.
  logic signed [TempW-1:0] line_q [LineLen];

  logic [RowCntW-1:0] row_q, new_row_q;
  logic [ColCntW-1:0] col_q, new_col_q;
  logic [AddrW-1:0]   idx_q, new_idx_q;
  logic               v0_q, v1_q, v2_q, v3_q, v4_q;

  logic signed [PartW-1:0] pa_q, pb_q;
  logic signed [TempW-1:0] old1_q, old2_q, old3_q;
  logic [AddrW-1:0]        addr1_q, addr2_q, addr3_q, addr4_q;
  logic                    neg2_q, neg3_q;
  logic [MagW-1:0]         mag2_q;
  logic [ProdW-1:0]        prod3_q;
  logic signed [TempW-1:0] new4_q;
  logic [DiffW-1:0]        diff4_q;
  logic [ChangeW-1:0]      total_q;

  logic                    interior;
  logic signed [PartW-1:0] pa_d, pb_d;
  logic signed [SumW-1:0]  sum_d;
  logic signed [SumW-1:0]  abs_d;
  logic [TempW-1:0]        quot_d;
  logic signed [TempW-1:0] new_d;
  logic signed [DiffW-1:0] diff_d;
  logic [DiffW-1:0]        adiff_d;
  logic [ChangeW:0]        total_d;

  assign interior = (new_row_q >= RowCntW'(2)) && (new_col_q >= ColCntW'(2));

  assign pa_d = PartW'(line_q[2*Cols]) + PartW'(line_q[2*Cols+1]) + PartW'(line_q[2*Cols+2])
              + PartW'(line_q[Cols]) + PartW'(line_q[Cols+1]);
  assign pb_d = PartW'(line_q[Cols+1]) + PartW'(line_q[Cols+2])
              + PartW'(line_q[0]) + PartW'(line_q[1]) + PartW'(line_q[2]);

  assign sum_d   = SumW'(pa_q) + SumW'(pb_q);
  assign abs_d   = (sum_d < 0) ? -sum_d : sum_d;
  assign quot_d  = prod3_q[RECIP_SHIFT +: TempW];
  assign new_d   = neg3_q ? -$signed(quot_d) : $signed(quot_d);
  assign diff_d  = DiffW'(old3_q) - DiffW'(new_d);
  assign adiff_d = (diff_d < 0) ? DiffW'(-diff_d) : DiffW'(diff_d);
  assign total_d = (ChangeW + 1)'(total_q) + (ChangeW + 1)'(diff4_q);

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      line_q[0] <= in_data_i;
      for (int k = 1; k < LineLen; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    old1_q  <= line_q[Cols+1];
    addr1_q <= new_idx_q - AddrW'(Cols + 1);
    neg2_q  <= sum_d < 0;
    mag2_q  <= abs_d[MagW-1:0];
    old2_q  <= old1_q;
    addr2_q <= addr1_q;
    prod3_q <= ProdW'(mag2_q) * ProdW'(RECIP10);
    neg3_q  <= neg2_q;
    old3_q  <= old2_q;
    addr3_q <= addr2_q;
    new4_q  <= new_d;
    diff4_q <= adiff_d;
    addr4_q <= addr3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      col_q     <= '0;
      idx_q     <= '0;
      new_row_q <= '0;
      new_col_q <= '0;
      new_idx_q <= '0;
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      total_q   <= '0;
    end else begin
      v0_q <= in_valid_i;
      v1_q <= v0_q && interior;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (start_i) begin
        row_q   <= '0;
        col_q   <= '0;
        idx_q   <= '0;
        total_q <= '0;
      end else begin
        if (in_valid_i) begin
          new_row_q <= row_q;
          new_col_q <= col_q;
          new_idx_q <= idx_q;
          idx_q     <= idx_q + AddrW'(1);
          if (col_q == ColCntW'(Cols - 1)) begin
            col_q <= '0;
            row_q <= row_q + RowCntW'(1);
          end else begin
            col_q <= col_q + ColCntW'(1);
          end
        end
        if (v4_q) begin
          total_q <= total_d[ChangeW] ? '1 : total_d[ChangeW-1:0];
        end
      end
    end
  end

  assign wr_valid_o = v4_q;
  assign wr_addr_o  = addr4_q;
  assign wr_data_o  = new4_q;
  assign total_o    = total_q;
  assign busy_o     = v0_q || v1_q || v2_q || v3_q || v4_q;

endmodule

>>> rtl/core/phs_level.sv
module phs_level (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [phs_pkg::TempW-1:0]  value_i,
  input  logic signed [phs_pkg::TempW-1:0]  high_i,
  input  logic signed [phs_pkg::TempW-1:0]  low_i,
  output logic                              done_o,
  output logic [phs_pkg::LevelW-1:0]        level_o
);
  import phs_pkg::*;

  localparam int SpanW = TempW + 1;
  localparam int NumW  = TempW + 5;

  logic signed [SpanW-1:0] span_d, dist_d;
  logic signed [NumW-1:0]  num_d;
  logic                    empty_d;

  logic                    busy_q, done_q;
  logic [LevelW-1:0]       level_q;
  logic [NumW-2:0]         num_q;
  logic [TempW-1:0]        span_q;
  logic [NumW-1:0]         acc_q;

  assign span_d  = SpanW'(high_i) - SpanW'(low_i);
  assign dist_d  = SpanW'(value_i) - SpanW'(low_i);
  assign num_d   = (NumW'(dist_d) <<< 3) + NumW'(dist_d);
  assign empty_d = (span_d <= 0) || (num_d < 0);

  // The level is the number of multiples of the span, up to nine, that fit under the numerator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_d[NumW-2:0];
      span_q <= span_d[TempW-1:0];
      acc_q  <= NumW'(span_d[TempW-1:0]);
    end else if (busy_q) begin
      acc_q <= acc_q + NumW'(span_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      level_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        level_q <= '0;
        busy_q  <= !empty_d;
        done_q  <= empty_d;
      end else if (busy_q) begin
        if ((level_q != LEVEL_MAX) && (NumW'(num_q) >= acc_q)) begin
          level_q <= level_q + LevelW'(1);
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

>>> rtl/core/plate_heat_stencil_step_top.sv
// Heat-diffusion plate of Rows x Cols signed Q15.8 cells held in one synchronous RAM.
// A write word writes its cell, if on the plate, into the RAM. A read word reads its cell
// from the RAM and then hands it to the level unit, which tries one multiple of the range
// per cycle. A step word sweeps the plate through the single RAM read port at one cell per
// cycle and then drains the stencil pipeline; new values are written back a little over
// one row behind the read sweep, to cells that the sweep has already passed.
module plate_heat_stencil_step_top #(
  parameter int unsigned Rows = phs_pkg::RowsDefault,
  parameter int unsigned Cols = phs_pkg::ColsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  phs_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output phs_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [phs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [phs_pkg::CfgDataW-1:0]      cfg_data_i
);
  import phs_pkg::*;

  localparam int unsigned Cells = Rows * Cols;
  localparam int          AddrW = $clog2(Cells);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_LVL   = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]              st_q, st_d;
  logic [AddrW-1:0]        rd_cnt_q;
  logic                    rdv_q;
  logic                    in_plate_q;
  logic signed [TempW-1:0] temp_q;
  logic [StepW-1:0]        steps_q;
  logic [ChangeW-1:0]      change_q;
  logic                    settled_q;
  logic signed [TempW-1:0] high_q, low_q;
  logic [ChangeW-1:0]      thr_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic                    accept;
  logic                    in_plate;
  logic [AddrW-1:0]        cmd_addr;
  logic                    mem_we;
  logic [AddrW-1:0]        mem_waddr, mem_raddr;
  logic [TempW-1:0]        mem_wdata, mem_rdata;
  logic                    sten_start;
  logic                    sten_wr_valid;
  logic [AddrW-1:0]        sten_wr_addr;
  logic signed [TempW-1:0] sten_wr_data;
  logic [ChangeW-1:0]      sten_total;
  logic                    sten_busy;
  logic                    lvl_start, lvl_done;
  logic [LevelW-1:0]       lvl_level;
  logic                    step_done;

  assign in_ready_o = (st_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_plate   = (32'(in_data_i.row) < Rows) && (32'(in_data_i.col) < Cols);
  assign cmd_addr   = AddrW'(32'(in_data_i.row) * Cols + 32'(in_data_i.col));

  assign mem_we    = (accept && (in_data_i.command == CMD_WRITE) && in_plate) || sten_wr_valid;
  assign mem_waddr = sten_wr_valid ? sten_wr_addr : cmd_addr;
  assign mem_wdata = sten_wr_valid ? sten_wr_data : in_data_i.temperature;
  assign mem_raddr = (st_q == S_STEP) ? rd_cnt_q : cmd_addr;

  assign sten_start = accept && (in_data_i.command == CMD_STEP);
  assign lvl_start  = (st_q == S_RD) && in_plate_q;
  assign step_done  = (st_q == S_DRAIN) && !rdv_q && !sten_busy;

  phs_ram #(
    .Width (TempW),
    .Depth (Cells)
  ) u_plate (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  phs_stencil #(
    .Rows (Rows),
    .Cols (Cols)
  ) u_stencil (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sten_start),
    .in_valid_i (rdv_q),
    .in_data_i  (mem_rdata),
    .wr_valid_o (sten_wr_valid),
    .wr_addr_o  (sten_wr_addr),
    .wr_data_o  (sten_wr_data),
    .total_o    (sten_total),
    .busy_o     (sten_busy)
  );

  phs_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lvl_start),
    .value_i (mem_rdata),
    .high_i  (high_q),
    .low_i   (low_q),
    .done_o  (lvl_done),
    .level_o (lvl_level)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.command)
            CMD_STEP: st_d = S_STEP;
            CMD_READ: st_d = S_RD;
            default:  st_d = S_IDLE;
          endcase
        end
      end
      S_RD:    st_d = in_plate_q ? S_LVL : S_IDLE;
      S_LVL:   st_d = lvl_done ? S_IDLE : S_LVL;
      S_STEP:  st_d = (rd_cnt_q == AddrW'(Cells - 1)) ? S_DRAIN : S_STEP;
      S_DRAIN: st_d = step_done ? S_IDLE : S_DRAIN;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_plate_q <= in_plate;
    end
    if (lvl_start) begin
      temp_q <= mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      rd_cnt_q    <= '0;
      rdv_q       <= 1'b0;
      steps_q     <= '0;
      change_q    <= '0;
      settled_q   <= 1'b0;
      high_q      <= RANGE_HIGH_RST;
      low_q       <= RANGE_LOW_RST;
      thr_q       <= THRESHOLD_RST;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q  <= st_d;
      rdv_q <= (st_q == S_STEP);
      if (sten_start) begin
        rd_cnt_q <= '0;
      end else if (st_q == S_STEP) begin
        rd_cnt_q <= rd_cnt_q + AddrW'(1);
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RANGE_HIGH: high_q <= cfg_data_i[TempW-1:0];
          CFG_RANGE_LOW:  low_q  <= cfg_data_i[TempW-1:0];
          CFG_THRESHOLD:  thr_q  <= cfg_data_i[ChangeW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (accept && (in_data_i.command != CMD_STEP) && (in_data_i.command != CMD_READ)) begin
        out_valid_q <= 1'b1;
        out_q       <= '{cell_temp: '0, level: '0, step_count: steps_q,
                         total_change: change_q, converged: settled_q};
      end else if ((st_q == S_RD) && !in_plate_q) begin
        out_valid_q <= 1'b1;
        out_q       <= '{cell_temp: '0, level: '0, step_count: steps_q,
                         total_change: change_q, converged: settled_q};
      end else if ((st_q == S_LVL) && lvl_done) begin
        out_valid_q <= 1'b1;
        out_q       <= '{cell_temp: temp_q, level: lvl_level, step_count: steps_q,
                         total_change: change_q, converged: settled_q};
      end else if (step_done) begin
        if (steps_q != '1) begin
          steps_q <= steps_q + StepW'(1);
        end
        change_q    <= sten_total;
        settled_q   <= settled_q || (sten_total <= thr_q);
        out_valid_q <= 1'b1;
        out_q       <= '{cell_temp: '0, level: '0,
                         step_count: (steps_q != '1) ? steps_q + StepW'(1) : steps_q,
                         total_change: sten_total,
                         converged: settled_q || (sten_total <= thr_q)};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The stencil only writes back while a step is being swept or drained.
  a_wb_only_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sten_wr_valid |-> ((st_q == S_STEP) || (st_q == S_DRAIN)))
    else $error("stencil write-back outside a step");

  a_steps_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (steps_q >= $past(steps_q)))
    else $error("step count went backwards");

  a_settled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settled_q |=> settled_q)
    else $error("converged flag cleared");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.level <= LEVEL_MAX))
    else $error("level above nine");

endmodule
